// ===== rtl/ipv4hc_pkg.sv =====
// shared types, constants and codes for the ipv4 header checker
`timescale 1ns / 1ps

package ipv4hc_pkg;

    localparam int MAX_OPTIONS      = 40;
    localparam int MIN_HEADER_BYTES = 20;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [7:0]  OPT_END_OF_LIST  = 8'd0;
    localparam logic [7:0]  OPT_NO_OPERATION = 8'd1;
    localparam logic [5:0]  OPT_CURSOR_LIMIT = 6'd63;
    localparam logic [3:0]  IP_VERSION_4     = 4'd4;
    localparam logic [15:0] POS_LIMIT        = 16'hFFFF;
    localparam logic [15:0] CSUM_GOOD        = 16'hFFFF;
    localparam logic [15:0] FRAGMENT_OFFSET_MASK = 16'h1FFF;

    localparam logic [15:0] POS_TOTAL_LEN_LO = 16'd3;
    localparam logic [15:0] POS_FLAGS_LO     = 16'd7;
    localparam logic [15:0] POS_PROTOCOL     = 16'd9;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_TRUNCATED = 3'd1,
        STATUS_NOT_IPV4  = 3'd2,
        STATUS_BAD_HLEN  = 3'd3,
        STATUS_SHORT     = 3'd4,
        STATUS_BAD_CSUM  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        NOTE_AGREE = 2'd0,
        NOTE_LONG  = 2'd1,
        NOTE_SHORT = 2'd2
    } length_note_t;

    typedef enum logic [1:0] {
        FRAG_WHOLE  = 2'd0,
        FRAG_FIRST  = 2'd1,
        FRAG_MIDDLE = 2'd2,
        FRAG_LAST   = 2'd3
    } frag_kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } data_word_t;

    typedef struct packed {
        status_t      status;
        length_note_t length_note;
        logic [5:0]   header_length;
        logic [15:0]  payload_length;
        logic [7:0]   protocol;
        logic [2:0]   frag_flags;
        logic [12:0]  fragment_offset;
        frag_kind_t   frag_kind;
        logic [5:0]   option_count;
        logic         option_error;
    } result_word_t;

    // raw facts of one finished datagram, handed from front to back
    typedef struct packed {
        logic [15:0] capture_length;
        logic [7:0]  version_ihl;
        logic [15:0] total_length;
        logic [15:0] flags_offset;
        logic [7:0]  protocol;
        logic [15:0] checksum_sum;
        logic [5:0]  options_walked;
        logic        option_fault;
    } summary_t;

endpackage

// ===== rtl/ipv4_header_checker_core.sv =====
// top level of the streaming ipv4 header checker
`timescale 1ns / 1ps

// Streaming IPv4 header checker. A captured datagram enters one byte per data
// word, header first, with is_last on its final captured byte; the block takes
// one byte every clock while data_stall is low, datagrams back to back, and
// needs no gap between them. The byte front end tracks position (saturating
// at 65535), latches the fixed header fields, folds the header words into a
// ones' complement sum and walks the option list. On the last byte it hands a
// summary into a two-entry queue; the back end turns that into one result
// word, registered onto the result port when the back end pops the queue
// head, which it does while its output is empty or not stalled. data_stall
// rises while the queue is full and then holds off whatever byte is offered;
// the queue only fills when the result port stalls across several datagrams.
// Verdicts go in priority order: truncated, not version 4, bad header
// length, length below header, bad checksum (the last only while
// checksum_check_enable is set, its reset value). For any status other than
// ok all other fields read zero. Write the enable only when the block is idle.

module ipv4_header_checker_core (
    input  logic                     clk,
    input  logic                     rst_n,
    // checksum check enable register
    input  logic                     cfg_write_enable,
    input  logic                     cfg_write_data,
    // byte stream
    input  logic                     data_valid,
    output logic                     data_stall,
    input  ipv4hc_pkg::data_word_t   data_word,
    // verdicts
    output logic                     result_valid,
    input  logic                     result_stall,
    output ipv4hc_pkg::result_word_t result_word
);
    import ipv4hc_pkg::*;

    logic     csum_enable_reg;
    logic     summary_push;
    summary_t summary;
    logic     head_valid;
    summary_t head_data;
    logic     queue_full;
    logic     pop;

    // config register, reset to checking on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            csum_enable_reg <= 1'b1;
        end
        else if (cfg_write_enable)
        begin
            csum_enable_reg <= cfg_write_data;
        end
    end

    // stall whenever no room for a summary, whichever byte is offered
    assign data_stall = queue_full;

    ipv4hc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_valid   (data_valid),
        .data_word    (data_word),
        .queue_full   (queue_full),
        .summary_push (summary_push),
        .summary      (summary)
    );

    ipv4hc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (summary_push),
        .push_data  (summary),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data),
        .full       (queue_full)
    );

    ipv4hc_back u_back (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .head_valid            (head_valid),
        .head_data             (head_data),
        .checksum_check_enable (csum_enable_reg),
        .result_stall          (result_stall),
        .pop                   (pop),
        .result_valid          (result_valid),
        .result_word           (result_word)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        queue_full |-> !summary_push)
        else $error("summary pushed into full queue");

endmodule

// ===== rtl/ipv4hc_front.sv =====
// byte front end: position, header field capture, checksum fold and option walk
`timescale 1ns / 1ps

module ipv4hc_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   data_valid,
    input  ipv4hc_pkg::data_word_t data_word,
    input  logic                   queue_full,
    output logic                   summary_push,
    output ipv4hc_pkg::summary_t   summary
);
    import ipv4hc_pkg::*;

    localparam logic [5:0] MAX_OPT_COUNT = 6'(MAX_OPTIONS);
    localparam logic [5:0] MIN_HDR       = 6'(MIN_HEADER_BYTES);

    logic [15:0] pos_reg, pos_next;
    logic [15:0] csum_reg, csum_next;
    logic [7:0]  hold_reg, hold_next;
    logic [7:0]  vi_reg, vi_next;
    logic [15:0] tlen_reg, tlen_next;
    logic [15:0] fo_reg, fo_next;
    logic [7:0]  proto_reg, proto_next;
    logic [5:0]  next_opt_reg, next_opt_next;
    logic [5:0]  walked_reg, walked_next;
    logic        await_reg, await_next;
    logic        stopped_reg, stopped_next;
    logic        fault_reg, fault_next;

    logic        accept;
    logic [7:0]  b;
    logic [5:0]  hlen;
    logic        in_header;
    logic [15:0] hdr_word;
    logic [16:0] sum_wide;
    logic [8:0]  cursor_sum;

    assign accept = data_valid && !queue_full;
    assign b      = data_word.data_byte;

    always_comb
    begin
        vi_next       = (pos_reg == 16'd0) ? b : vi_reg;
        hlen          = {vi_next[3:0], 2'b00};
        in_header     = pos_reg < {10'd0, hlen};
        hdr_word      = {hold_reg, b};
        tlen_next     = (pos_reg == POS_TOTAL_LEN_LO) ? hdr_word : tlen_reg;
        fo_next       = (pos_reg == POS_FLAGS_LO) ? hdr_word : fo_reg;
        proto_next    = (pos_reg == POS_PROTOCOL) ? b : proto_reg;
        hold_next     = b;

        // end-around carry fold on each completed header word
        sum_wide  = {1'b0, csum_reg} + {1'b0, hdr_word};
        csum_next = csum_reg;
        if (pos_reg[0] && in_header)
        begin
            csum_next = sum_wide[15:0] + {15'd0, sum_wide[16]};
        end

        next_opt_next = next_opt_reg;
        walked_next   = walked_reg;
        await_next    = await_reg;
        stopped_next  = stopped_reg;
        fault_next    = fault_reg;
        cursor_sum    = {3'd0, next_opt_reg} + {1'b0, b};
        if (pos_reg >= {10'd0, MIN_HDR} && in_header && !stopped_reg)
        begin
            if (await_reg)
            begin
                await_next = 1'b0;
                if (b < 8'd2)
                begin
                    stopped_next = 1'b1;
                    fault_next   = 1'b1;
                end
                else
                begin
                    next_opt_next = (cursor_sum > {3'd0, OPT_CURSOR_LIMIT}) ?
                                    OPT_CURSOR_LIMIT : cursor_sum[5:0];
                end
            end
            else if (pos_reg == {10'd0, next_opt_reg})
            begin
                if (walked_reg >= MAX_OPT_COUNT)
                begin
                    stopped_next = 1'b1;
                end
                else
                begin
                    walked_next = walked_reg + 6'd1;
                    if (b == OPT_END_OF_LIST)
                    begin
                        stopped_next = 1'b1;
                    end
                    else if (b == OPT_NO_OPERATION)
                    begin
                        next_opt_next = next_opt_reg + 6'd1;
                    end
                    else
                    begin
                        await_next = 1'b1;
                    end
                end
            end
        end

        pos_next = (pos_reg == POS_LIMIT) ? pos_reg : pos_reg + 16'd1;

        summary.capture_length = pos_next;
        summary.version_ihl    = vi_next;
        summary.total_length   = tlen_next;
        summary.flags_offset   = fo_next;
        summary.protocol       = proto_next;
        summary.checksum_sum   = csum_next;
        summary.options_walked = walked_next;
        summary.option_fault   = fault_next;
    end

    assign summary_push = accept && data_word.is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            csum_reg     <= '0;
            hold_reg     <= '0;
            vi_reg       <= '0;
            tlen_reg     <= '0;
            fo_reg       <= '0;
            proto_reg    <= '0;
            next_opt_reg <= MIN_HDR;
            walked_reg   <= '0;
            await_reg    <= 1'b0;
            stopped_reg  <= 1'b0;
            fault_reg    <= 1'b0;
        end
        else if (accept)
        begin
            if (data_word.is_last)
            begin
                pos_reg      <= '0;
                csum_reg     <= '0;
                hold_reg     <= '0;
                vi_reg       <= '0;
                tlen_reg     <= '0;
                fo_reg       <= '0;
                proto_reg    <= '0;
                next_opt_reg <= MIN_HDR;
                walked_reg   <= '0;
                await_reg    <= 1'b0;
                stopped_reg  <= 1'b0;
                fault_reg    <= 1'b0;
            end
            else
            begin
                pos_reg      <= pos_next;
                csum_reg     <= csum_next;
                hold_reg     <= hold_next;
                vi_reg       <= vi_next;
                tlen_reg     <= tlen_next;
                fo_reg       <= fo_next;
                proto_reg    <= proto_next;
                next_opt_reg <= next_opt_next;
                walked_reg   <= walked_next;
                await_reg    <= await_next;
                stopped_reg  <= stopped_next;
                fault_reg    <= fault_next;
            end
        end
    end

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        summary_push |=> (pos_reg == 16'd0 && walked_reg == 6'd0 && !stopped_reg))
        else $error("front state not cleared after last byte");

    a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        walked_reg <= MAX_OPT_COUNT)
        else $error("option count beyond maximum");

endmodule

// ===== rtl/ipv4hc_queue.sv =====
// short summary queue between front and back
`timescale 1ns / 1ps

module ipv4hc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ipv4hc_pkg::summary_t push_data,
    input  logic                 pop,
    output logic                 head_valid,
    output ipv4hc_pkg::summary_t head_data,
    output logic                 full
);
    import ipv4hc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    summary_t          store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == DEPTH_CNT);
    assign head_data  = store_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("queue count beyond depth");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> head_valid)
        else $error("queue empty after push");

endmodule

// ===== rtl/ipv4hc_back.sv =====
// verdict back end: checks in priority order and holds the result word
`timescale 1ns / 1ps

module ipv4hc_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     head_valid,
    input  ipv4hc_pkg::summary_t     head_data,
    input  logic                     checksum_check_enable,
    input  logic                     result_stall,
    output logic                     pop,
    output logic                     result_valid,
    output ipv4hc_pkg::result_word_t result_word
);
    import ipv4hc_pkg::*;

    localparam logic [15:0] MIN_HDR16 = 16'(MIN_HEADER_BYTES);

    logic         valid_reg, valid_next;
    result_word_t word_reg, word_next;
    logic [5:0]   hlen;
    logic [15:0]  hlen16;
    logic [15:0]  eff;
    status_t      status;
    length_note_t note;
    logic         more_frags;
    logic         offset_nz;
    frag_kind_t   kind;

    assign pop = head_valid && (!valid_reg || !result_stall);

    always_comb
    begin
        hlen   = {head_data.version_ihl[3:0], 2'b00};
        hlen16 = {10'd0, hlen};
        status = STATUS_OK;
        note   = NOTE_AGREE;
        eff    = head_data.total_length;
        if (head_data.capture_length < MIN_HDR16)
        begin
            status = STATUS_TRUNCATED;
        end
        else if (head_data.version_ihl[7:4] != IP_VERSION_4)
        begin
            status = STATUS_NOT_IPV4;
        end
        else if (hlen16 < MIN_HDR16)
        begin
            status = STATUS_BAD_HLEN;
        end
        else
        begin
            if (head_data.total_length > head_data.capture_length)
            begin
                note = NOTE_LONG;
                eff  = head_data.capture_length;
            end
            else if (head_data.total_length < head_data.capture_length)
            begin
                note = NOTE_SHORT;
            end
            if (eff < hlen16)
            begin
                status = STATUS_SHORT;
            end
            else if (checksum_check_enable && head_data.checksum_sum != CSUM_GOOD)
            begin
                status = STATUS_BAD_CSUM;
            end
        end

        more_frags = head_data.flags_offset[13];
        offset_nz  = (head_data.flags_offset & FRAGMENT_OFFSET_MASK) != 16'd0;
        case ({more_frags, offset_nz})
            2'b00:   kind = FRAG_WHOLE;
            2'b10:   kind = FRAG_FIRST;
            2'b11:   kind = FRAG_MIDDLE;
            2'b01:   kind = FRAG_LAST;
            default: kind = FRAG_WHOLE;
        endcase

        word_next        = '0;
        word_next.status = status;
        if (status == STATUS_OK)
        begin
            word_next.length_note     = note;
            word_next.header_length   = hlen;
            word_next.payload_length  = eff - hlen16;
            word_next.protocol        = head_data.protocol;
            word_next.frag_flags      = head_data.flags_offset[15:13];
            word_next.fragment_offset = head_data.flags_offset[12:0];
            word_next.frag_kind       = kind;
            word_next.option_count    = head_data.options_walked;
            word_next.option_error    = head_data.option_fault;
        end

        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            word_reg <= word_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign result_valid = valid_reg;
    assign result_word  = word_reg;

    a_bad_has_no_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && word_reg.status != STATUS_OK) |->
        (word_reg.header_length == 6'd0 && word_reg.payload_length == 16'd0
         && word_reg.option_count == 6'd0))
        else $error("rejected datagram carries decoded fields");

    a_ok_header_min: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && word_reg.status == STATUS_OK) |->
        ({10'd0, word_reg.header_length} >= MIN_HDR16))
        else $error("accepted datagram with short header");

endmodule
